@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the interrupt bitmap block.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Checks that a condition in one cycle implies a consequence in the next one.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/irsb_pkg.sv @@
// Shared types and constants of the interrupt request and in-service bitmap block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package irsb_pkg;

	localparam int WORD_BITS = 64;

	typedef enum logic [1:0] {
		REQ_POST = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_EOI  = 2'd2
	} req_t;

	typedef struct packed {
		logic [7:0] vector_out;
		logic       spurious;
		logic       request_pending;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/irsb_pick.sv @@
// Priority pick over the pending bitmap: highest nonzero 64-bit word, lowest bit in it.
// Depends on irsb_pkg for the word size.
`default_nettype none

module irsb_pick #(
	parameter int NUM_VECTORS = 256
) (
	input  wire logic [((NUM_VECTORS + irsb_pkg::WORD_BITS - 1) / irsb_pkg::WORD_BITS)
	                   * irsb_pkg::WORD_BITS - 1:0] bits,
	output logic found,
	output logic [$clog2(((NUM_VECTORS + irsb_pkg::WORD_BITS - 1) / irsb_pkg::WORD_BITS)
	                     * irsb_pkg::WORD_BITS) - 1:0] vector
);

	localparam int WORD_COUNT = (NUM_VECTORS + irsb_pkg::WORD_BITS - 1) / irsb_pkg::WORD_BITS;
	localparam int BITS = WORD_COUNT * irsb_pkg::WORD_BITS;
	localparam int VEC_W = $clog2(BITS);
	localparam int POS_W = $clog2(irsb_pkg::WORD_BITS);

	logic [irsb_pkg::WORD_BITS-1:0] sel_word;
	logic [irsb_pkg::WORD_BITS-1:0] low_bit;
	logic [VEC_W-1:0]               sel_base;
	logic [POS_W-1:0]               pos;

	// Later words overwrite earlier ones, so the highest nonzero word wins.
	always_comb begin
		sel_word = '0;
		sel_base = '0;
		found    = 1'b0;
		for (int w = 0; w < WORD_COUNT; w++) begin
			if (|bits[w*irsb_pkg::WORD_BITS +: irsb_pkg::WORD_BITS]) begin
				sel_word = bits[w*irsb_pkg::WORD_BITS +: irsb_pkg::WORD_BITS];
				sel_base = VEC_W'(w * irsb_pkg::WORD_BITS);
				found    = 1'b1;
			end
		end
	end

	// Isolate the lowest set bit, then encode the one-hot result.
	assign low_bit = sel_word & (~sel_word + irsb_pkg::WORD_BITS'(1));

	always_comb begin
		pos = '0;
		for (int b = 0; b < irsb_pkg::WORD_BITS; b++) begin
			if (low_bit[b]) begin
				pos = pos | POS_W'(b);
			end
		end
	end

	assign vector = sel_base | VEC_W'(pos);

endmodule

`default_nettype wire

@@ rtl/irsb_core.sv @@
// Pending and in-service bitmaps with their update for post, acknowledge and end of interrupt.
// Depends on irsb_pkg, irsb_pick and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irsb_core #(
	parameter int NUM_VECTORS = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [1:0]    req_type,
	input  wire logic [7:0]    vector_in,
	output irsb_pkg::res_t     result
);

	localparam int WORD_COUNT = (NUM_VECTORS + irsb_pkg::WORD_BITS - 1) / irsb_pkg::WORD_BITS;
	localparam int BITS = WORD_COUNT * irsb_pkg::WORD_BITS;
	localparam int VEC_W = $clog2(BITS);

	logic [BITS-1:0]  pending_q;
	logic [BITS-1:0]  in_service_q;
	logic             any_pending_q;
	logic [BITS-1:0]  pending_d;
	logic [BITS-1:0]  in_service_d;
	logic             any_pending_d;
	logic [BITS-1:0]  vec_mask;
	logic [BITS-1:0]  pick_mask;
	logic             in_range;
	logic             pick_found;
	logic [VEC_W-1:0] pick_vec;

	irsb_pick #(
		.NUM_VECTORS(NUM_VECTORS)
	) u_pick (
		.bits   (pending_q),
		.found  (pick_found),
		.vector (pick_vec)
	);

	assign in_range  = 32'(vector_in) < 32'(NUM_VECTORS);
	assign vec_mask  = BITS'(1) << vector_in;
	assign pick_mask = BITS'(1) << pick_vec;

	always_comb begin
		pending_d              = pending_q;
		in_service_d           = in_service_q;
		any_pending_d          = any_pending_q;
		result.vector_out      = '0;
		result.spurious        = 1'b0;
		case (irsb_pkg::req_t'(req_type))
			irsb_pkg::REQ_POST: begin
				if (in_range) begin
					pending_d     = pending_q | vec_mask;
					any_pending_d = 1'b1;
				end
			end
			irsb_pkg::REQ_ACK: begin
				if (pick_found) begin
					pending_d         = pending_q & ~pick_mask;
					in_service_d      = in_service_q | pick_mask;
					result.vector_out = 8'(pick_vec);
					if (!(|(pending_q & ~pick_mask))) begin
						any_pending_d = 1'b0;
					end
				end else begin
					result.spurious = 1'b1;
				end
			end
			irsb_pkg::REQ_EOI: begin
				if (in_range) begin
					in_service_d = in_service_q & ~vec_mask;
				end
			end
			default: begin
			end
		endcase
		result.request_pending = any_pending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			in_service_q  <= '0;
			any_pending_q <= 1'b0;
		end else if (step) begin
			pending_q     <= pending_d;
			in_service_q  <= in_service_d;
			any_pending_q <= any_pending_d;
		end
	end

	// The summary flag must always agree with the bitmap it summarizes.
	`ASSERT_ALWAYS(a_any_matches_bitmap, clk, arst_n, any_pending_q == (|pending_q))
	// A spurious acknowledge leaves both bitmaps untouched.
	`ASSERT_NEXT(a_spurious_no_change, clk, arst_n,
		step && (req_type == irsb_pkg::REQ_ACK) && !pick_found,
		$stable(pending_q) && $stable(in_service_q))
	// A successful acknowledge removes exactly one pending bit.
	`ASSERT_NEXT(a_ack_takes_one, clk, arst_n,
		step && (req_type == irsb_pkg::REQ_ACK) && pick_found,
		$countones(pending_q) == $past($countones(pending_q)) - 1)

endmodule

`default_nettype wire

@@ rtl/interrupt_request_service_bitmap.sv @@
// Path: a word goes into the input register, then its result into the result register.
// Throughput: one word per cycle while out_ready allows the result register to drain.
// The pick is a priority encode over all pending bits between the input and result registers.
// Reset (arst_n low, asynchronous) clears both bitmaps, the pending flag and all valid bits.
// Depends on irsb_pkg and irsb_core.
`default_nettype none

module interrupt_request_service_bitmap #(
	parameter int NUM_VECTORS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] vector_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      vector_out,
	output logic            spurious,
	output logic            request_pending
);

	logic           valid_s1;
	logic [1:0]     req_type_s1;
	logic [7:0]     vector_s1;
	logic           valid_s2;
	irsb_pkg::res_t result_s2;
	irsb_pkg::res_t result;
	logic           advance;

	// The stage-one word is processed when the result register is free or being drained.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	irsb_core #(
		.NUM_VECTORS(NUM_VECTORS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.req_type  (req_type_s1),
		.vector_in (vector_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			vector_s1   <= vector_in;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign vector_out      = result_s2.vector_out;
	assign spurious        = result_s2.spurious;
	assign request_pending = result_s2.request_pending;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for interrupt_request_service_bitmap: posts, acknowledges and
// ends of interrupt are pushed through the request channel and the replies are
// compared against a bitmap model kept in this file. Depends on irsb_pkg.
`timescale 1ns / 1ps

module tb;

	localparam int NUM_VECTORS = 256;
	localparam int MAP_WORDS = NUM_VECTORS / irsb_pkg::WORD_BITS;
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam int RANDOM_PER_PHASE = 210;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam bit TYPED = 1'b1;
	localparam bit MODEL = 1'b0;

	typedef struct packed {
		logic [1:0]     kind;
		logic [7:0]     vec;
		logic           typed;
		irsb_pkg::res_t want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;

	// Rows marked TYPED carry a reply that is plain from the bitmap rules; the rest
	// are checked against the model below.
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{irsb_pkg::REQ_ACK,  8'h00,  TYPED, '{8'd0,   1'b1, 1'b0}},
		'{irsb_pkg::REQ_EOI,  8'h00,  TYPED, '{8'd0,   1'b0, 1'b0}},
		'{REQ_RESERVED,       8'hFF,  TYPED, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_POST, 8'd255, TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_POST, 8'd0,   TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_POST, 8'd63,  TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_POST, 8'd64,  TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_POST, 8'd128, TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'hAA,  TYPED, '{8'd255, 1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'h55,  TYPED, '{8'd128, 1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'hFF,  TYPED, '{8'd64,  1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'h00,  TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'h00,  TYPED, '{8'd63,  1'b0, 1'b0}},
		'{irsb_pkg::REQ_ACK,  8'h3C,  TYPED, '{8'd0,   1'b1, 1'b0}},
		'{irsb_pkg::REQ_EOI,  8'd255, TYPED, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_POST, 8'd200, MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_POST, 8'd192, MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_POST, 8'd5,   MODEL, '{8'd0,   1'b0, 1'b0}},
		'{REQ_RESERVED,       8'd192, TYPED, '{8'd0,   1'b0, 1'b1}},
		'{irsb_pkg::REQ_ACK,  8'h00,  MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_EOI,  8'd63,  MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_ACK,  8'hFF,  MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_ACK,  8'h81,  MODEL, '{8'd0,   1'b0, 1'b0}},
		'{irsb_pkg::REQ_EOI,  8'd192, MODEL, '{8'd0,   1'b0, 1'b0}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [7:0] vector_in;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] vector_out;
	logic       spurious;
	logic       request_pending;

	logic [irsb_pkg::WORD_BITS-1:0] pending_map [0:MAP_WORDS-1];
	logic [irsb_pkg::WORD_BITS-1:0] in_service_map [0:MAP_WORDS-1];
	logic                           any_pending_q;

	irsb_pkg::res_t awaited_replies [$];
	int             mismatch_count = 0;
	int             cycle_count = 0;
	int             src_idle_pct = 0;
	int             sink_stall_pct = 0;

	interrupt_request_service_bitmap #(
		.NUM_VECTORS(NUM_VECTORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.vector_in(vector_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vector_out(vector_out),
		.spurious(spurious),
		.request_pending(request_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one request to the bitmap model and returns the reply it produces.
	function automatic irsb_pkg::res_t serve_request(input logic [1:0] kind,
			input logic [7:0] vec);
		irsb_pkg::res_t reply;
		int   w;
		int   pos;
		bit   found;
		int   sel_word;
		int   sel_bit;
		sel_word = vec / irsb_pkg::WORD_BITS;
		sel_bit = vec % irsb_pkg::WORD_BITS;
		reply = '0;
		found = 1'b0;
		if (kind == irsb_pkg::REQ_POST) begin
			if (vec < NUM_VECTORS) begin
				pending_map[sel_word][sel_bit] = 1'b1;
				any_pending_q = 1'b1;
			end
		end else if (kind == irsb_pkg::REQ_ACK) begin
			// Highest nonzero word wins; inside it the lowest set bit.
			for (w = MAP_WORDS - 1; w >= 0 && !found; w--) begin
				if (pending_map[w] != '0) begin
					pos = 0;
					while (pos < irsb_pkg::WORD_BITS - 1 && !pending_map[w][pos])
						pos++;
					pending_map[w][pos] = 1'b0;
					in_service_map[w][pos] = 1'b1;
					reply.vector_out = 8'(w * irsb_pkg::WORD_BITS + pos);
					found = 1'b1;
				end
			end
			if (!found)
				reply.spurious = 1'b1;
			else if (!(|{pending_map[0], pending_map[1], pending_map[2], pending_map[3]}))
				any_pending_q = 1'b0;
		end else if (kind == irsb_pkg::REQ_EOI) begin
			if (vec < NUM_VECTORS)
				in_service_map[sel_word][sel_bit] = 1'b0;
		end
		reply.request_pending = any_pending_q;
		return reply;
	endfunction

	// Sends one word, with random idle cycles ahead of it; entered and left at a
	// falling edge.
	task automatic send_request(input logic [1:0] kind, input logic [7:0] vec,
			input bit typed, input irsb_pkg::res_t want);
		irsb_pkg::res_t reply;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		vector_in <= vec;
		do
			@(posedge clk);
		while (!in_ready);
		reply = serve_request(kind, vec);
		awaited_replies.push_back(typed ? want : reply);
		@(negedge clk);
	endtask

	// Picks a random request. Ends of interrupt mostly target a vector that is
	// really in service so that the post, acknowledge, end flow is exercised.
	task automatic pick_request(output logic [1:0] kind, output logic [7:0] vec);
		int roll;
		int start;
		int k;
		logic [7:0] cand;
		roll = $urandom_range(99);
		vec = 8'($urandom_range(255));
		if (roll < 40) begin
			kind = irsb_pkg::REQ_POST;
		end else if (roll < 75) begin
			kind = irsb_pkg::REQ_ACK;
		end else if (roll < 95) begin
			kind = irsb_pkg::REQ_EOI;
			if ($urandom_range(99) < 70) begin
				start = $urandom_range(255);
				for (k = 0; k < NUM_VECTORS; k++) begin
					cand = 8'(start + k);
					if (in_service_map[cand / irsb_pkg::WORD_BITS]
							[cand % irsb_pkg::WORD_BITS]) begin
						vec = cand;
						break;
					end
				end
			end
		end else begin
			kind = REQ_RESERVED;
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		irsb_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$error("reply word with no request outstanding: vector_out %0d", vector_out);
				mismatch_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (vector_out !== want.vector_out) begin
					$error("vector_out: expected %0d, got %0d", want.vector_out, vector_out);
					mismatch_count++;
				end
				if (spurious !== want.spurious) begin
					$error("spurious: expected %0b, got %0b", want.spurious, spurious);
					mismatch_count++;
				end
				if (request_pending !== want.request_pending) begin
					$error("request_pending: expected %0b, got %0b",
						want.request_pending, request_pending);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [1:0] kind;
		logic [7:0] vec;
		int phase;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = irsb_pkg::REQ_POST;
		vector_in = 8'd0;
		for (n = 0; n < MAP_WORDS; n++) begin
			pending_map[n] = '0;
			in_service_map[n] = '0;
		end
		any_pending_q = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++)
			send_request(directed_rows[n].kind, directed_rows[n].vec,
				directed_rows[n].typed, directed_rows[n].want);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick_request(kind, vec);
				send_request(kind, vec, MODEL, '0);
			end
		end
		in_valid <= 1'b0;

		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
